// File: design/aesctr_pkg.sv
// package: types, constants and functions of the aes counter mode cipher
`timescale 1ns / 1ps
package aesctr_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned RkDepth    = 30;
  localparam int unsigned RkAw       = 5;

  typedef enum logic [2:0] {
    REG_KEY_SIZE = 3'd0,
    REG_KEY_W0   = 3'd1,
    REG_KEY_W1   = 3'd2,
    REG_KEY_W2   = 3'd3,
    REG_KEY_W3   = 3'd4,
    REG_IV_HI    = 3'd5,
    REG_IV_LO    = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    KS_128 = 2'd0,
    KS_192 = 2'd1,
    KS_256 = 2'd2
  } key_size_t;

  typedef enum logic [2:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_RK0,
    ST_ROUND,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [63:0] in_hi;
    logic [63:0] in_lo;
    logic [4:0]  byte_count;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [4:0]  out_count;
  } out_item_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // one round without the round key addition (no mixcolumns when last) on a state laid out byte 0 at the top
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++)
        t[c*4 + k] = sbox(b[((c + k) % 4)*4 + k]);
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ al ^ xt(a0 ^ a1);
        t[c*4+1] = a1 ^ al ^ xt(a1 ^ a2);
        t[c*4+2] = a2 ^ al ^ xt(a2 ^ a3);
        t[c*4+3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
    return r;
  endfunction

endpackage

// File: design/aesctr_if.sv
// valid/ready channel interfaces for payload and configuration beats
`timescale 1ns / 1ps
interface aesctr_in_if;
  logic valid;
  logic ready;
  aesctr_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aesctr_out_if;
  logic valid;
  logic ready;
  aesctr_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aesctr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: design/aesctr_ram.sv
// generic ram with one write port and one read port, registered read
`timescale 1ns / 1ps
module aesctr_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/aes_counter_mode_cipher_top.sv
// aes counter mode cipher top level: key expansion, round sequencer, counter
//
//  channel   dir  beat
//  cfg       in   index 0..6 and 64-bit data
//  in_ch     in   in_hi, in_lo, byte_count, restart
//  out_ch    out  out_hi, out_lo, out_count
//
// the round key is read from a 30x64 ram, two words per round; the next item is taken
// only once the last round is done and its result has been taken on out_ch (an item
// with byte count zero is dropped without a result).
// a key or key-size write re-expands the schedule one 32-bit word per cycle;
// after reset the all-zero aes-128 key is expanded before the first item is taken.
// the result is held until taken; the next item waits until then.
`timescale 1ns / 1ps
module aes_counter_mode_cipher_top (
  input  logic clk,
  input  logic rst,
  aesctr_cfg_if.sink  cfg,
  aesctr_in_if.sink   in_ch,
  aesctr_out_if.source out_ch
);
  import aesctr_pkg::*;

  state_t state, state_next;
  logic [1:0]  key_size;
  logic [63:0] key_w [4];
  logic [63:0] iv_hi, iv_lo;
  logic [127:0] counter;
  logic [127:0] blk;
  in_item_t item;
  logic [3:0] round;
  logic [3:0] nr;
  logic [3:0] nk;
  logic       phase;
  logic [63:0] rk_hi;

  // key expansion registers
  logic [31:0] win [8];
  logic [5:0]  widx;
  logic [2:0]  wmod;
  logic [7:0]  rcon;
  logic [31:0] wnew;
  logic [31:0] wprev_even;
  logic        kick;

  logic          we;
  logic [RkAw-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  aesctr_ram #(.Width(64), .Depth(RkDepth)) u_rk (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  always_comb begin
    case (key_size)
      KS_128:  nk = 4'd4;
      KS_192:  nk = 4'd6;
      default: nk = 4'd8;
    endcase
    nr = nk + 4'd6;
  end

  assign cfg.ready = (state == ST_IDLE) || (state == ST_EXPAND);
  assign kick = cfg.valid && cfg.ready && (cfg.index <= REG_KEY_W3);
  assign in_ch.ready = (state == ST_IDLE) && !kick;

  // next schedule word; win is a sliding window of the last nk words
  always_comb begin
    logic [31:0] t;
    t = win[3'(nk - 4'd1)];
    if (wmod == 3'd0)
      t = sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
    else if (nk == 4'd8 && wmod == 3'd4)
      t = sub_word(t);
    wnew = win[0] ^ t;
  end

  always_comb begin
    we = 1'b0;
    waddr = widx[5:1];
    wdata = {wprev_even, wnew};
    if (state == ST_EXPAND && widx[0]) begin
      if (widx < 6'(nk)) begin
        we = 1'b1;
        wdata = key_w[widx[2:1]];
      end else if (widx < 6'(4 * (nr + 1))) begin
        we = 1'b1;
      end
    end
    // read one word ahead so each pair is complete when it is used
    raddr = '0;
    if ((state == ST_RK0 || state == ST_ROUND) && !(phase && round == nr))
      raddr = 5'(2 * round) + 5'(phase) + 5'd1;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_EXPAND: if (!kick && widx >= 6'(4 * (nr + 1))) state_next = ST_IDLE;
      ST_IDLE: begin
        if (kick) state_next = ST_EXPAND;
        else if (in_ch.valid) state_next = ST_RK0;
      end
      ST_RK0: if (item.byte_count == 5'd0) state_next = ST_IDLE;
              else if (phase) state_next = ST_ROUND;
      ST_ROUND: if (phase && round == nr) state_next = ST_OUT;
      ST_OUT: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
    if (kick) state_next = ST_EXPAND;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_EXPAND;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size <= KS_128;
      for (int i = 0; i < 4; i++) key_w[i] <= '0;
      iv_hi <= '0; iv_lo <= '0; counter <= '0;
      widx <= '0; round <= '0; phase <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_KEY_SIZE: key_size <= cfg.wdata[1:0];
          REG_KEY_W0:   key_w[0] <= cfg.wdata;
          REG_KEY_W1:   key_w[1] <= cfg.wdata;
          REG_KEY_W2:   key_w[2] <= cfg.wdata;
          REG_KEY_W3:   key_w[3] <= cfg.wdata;
          REG_IV_HI:    iv_hi <= cfg.wdata;
          REG_IV_LO:    iv_lo <= cfg.wdata;
          default: ;
        endcase
      end
      if (kick) begin
        widx <= '0;
      end else if (state == ST_EXPAND) begin
        if (widx < 6'(nk)) begin
          // first nk words are raw key, written in pairs while the window loads
          for (int i = 0; i < 8; i++)
            win[i] <= i[0] ? key_w[i/2][31:0] : key_w[i/2][63:32];
          rcon <= 8'h01; wmod <= '0;
          widx <= widx + 6'd1;
        end else if (widx < 6'(4 * (nr + 1))) begin
          for (int i = 0; i < 7; i++)
            win[i] <= (4'(i) == nk - 4'd1) ? wnew : win[i+1];
          if (nk == 4'd8) win[7] <= wnew;
          wprev_even <= wnew;
          wmod <= (wmod == 3'(nk - 4'd1)) ? 3'd0 : wmod + 3'd1;
          if (wmod == 3'd0) rcon <= xt(rcon);
          widx <= widx + 6'd1;
        end
      end
      if (state == ST_IDLE && in_ch.valid && in_ch.ready) begin
        item <= in_ch.data;
        if (in_ch.data.restart) counter <= {iv_hi, iv_lo};
        round <= '0; phase <= 1'b0;
      end
      if (state == ST_RK0) begin
        phase <= ~phase;
        if (phase) begin
          blk <= counter ^ {rk_hi, rdata};
          round <= 4'd1;
        end
      end
      if (state == ST_ROUND) begin
        phase <= ~phase;
        if (phase) begin
          blk <= aes_round(blk, round == nr) ^ {rk_hi, rdata};
          round <= round + 4'd1;
        end
      end
      if (state == ST_OUT && out_ch.ready) counter <= counter + 128'd1;
      rk_hi <= rdata;
    end
  end

  always_comb begin
    logic [4:0] n;
    logic [127:0] m;
    n = (item.byte_count > 5'd16) ? 5'd16 : item.byte_count;
    for (int i = 0; i < 16; i++) m[127 - 8*i -: 8] = (5'(i) < n) ? 8'hff : 8'h00;
    out_ch.data.out_hi = (blk[127:64] ^ item.in_hi) & m[127:64];
    out_ch.data.out_lo = (blk[63:0] ^ item.in_lo) & m[63:0];
    out_ch.data.out_count = n;
  end
  assign out_ch.valid = (state == ST_OUT);

endmodule
